FILE: design/bffy_pkg.sv
// ----------------------------------------------------------------------------
// bffy_pkg
// Shared constants, codes and controller/datapath interface types for the
// bit-frugal Fisher-Yates shuffler.
// ----------------------------------------------------------------------------
package bffy_pkg;

  localparam int STORE_DEPTH     = 64;
  localparam int SPAN_CAP_BITS   = 28;
  localparam int DECK_SIZE_RESET = 52;

  localparam int FIELD_W = 6;
  localparam int DECK_W  = 7;
  localparam int RANGE_W = FIELD_W + 1;
  localparam int SPAN_W  = SPAN_CAP_BITS + 1;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W   = $clog2(SPAN_W);

  localparam logic [1:0] OP_BIT  = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic KIND_SWAP = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_JLOAD,
    ST_JDIV,
    ST_RD_POS,
    ST_RD_J,
    ST_WR_POS,
    ST_WR_J,
    ST_RD_REQ,
    ST_RD_OUT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_POS,
    ADDR_J,
    ADDR_READ
  } addr_sel_t;

  typedef struct packed {
    logic      bit_step;
    logic      init;
    logic      read_cap;
    logic      div_step;
    logic      j_load;
    logic      j_step;
    addr_sel_t addr_sel;
    logic      cap_pos;
    logic      wr_pos;
    logic      wr_j;
    logic      emit_read;
  } dp_cmd_t;

  typedef struct packed {
    logic draw_ok;
  } dp_status_t;

endpackage

FILE: design/bffy_ram.sv
// ----------------------------------------------------------------------------
// bffy_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bffy_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bffy_ctrl.sv
// ----------------------------------------------------------------------------
// bffy_ctrl
// Controller: decodes accepted commands and sequences the divider steps,
// the quotient steps, the swap and the read through the card store.
// ----------------------------------------------------------------------------
module bffy_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           opcode,
  input  bffy_pkg::dp_status_t status,
  output bffy_pkg::dp_cmd_t    cmd,
  output logic                 busy
);
  import bffy_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    count_next   = count;
    cmd          = '0;
    cmd.addr_sel = ADDR_POS;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (opcode)
            OP_BIT: begin
              cmd.bit_step = 1'b1;
              if (status.draw_ok) begin
                state_next = ST_DIV;
                count_next = '0;
              end
            end
            OP_INIT: cmd.init = 1'b1;
            OP_READ: begin
              cmd.read_cap = 1'b1;
              state_next   = ST_RD_REQ;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (count == CNT_W'(SPAN_W - 1)) begin
          count_next = '0;
          state_next = ST_JLOAD;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      ST_JLOAD: begin
        cmd.j_load = 1'b1;
        count_next = '0;
        state_next = ST_JDIV;
      end
      ST_JDIV: begin
        cmd.j_step = 1'b1;
        if (count == CNT_W'(FIELD_W - 1)) begin
          count_next = '0;
          state_next = ST_RD_POS;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      ST_RD_POS: begin
        cmd.addr_sel = ADDR_POS;
        state_next   = ST_RD_J;
      end
      ST_RD_J: begin
        cmd.addr_sel = ADDR_J;
        cmd.cap_pos  = 1'b1;
        state_next   = ST_WR_POS;
      end
      ST_WR_POS: begin
        cmd.addr_sel = ADDR_J;
        cmd.wr_pos   = 1'b1;
        state_next   = ST_WR_J;
      end
      ST_WR_J: begin
        cmd.addr_sel = ADDR_J;
        cmd.wr_j     = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_RD_REQ: begin
        cmd.addr_sel = ADDR_READ;
        state_next   = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        cmd.addr_sel  = ADDR_READ;
        cmd.emit_read = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: design/bffy_dpath.sv
// ----------------------------------------------------------------------------
// bffy_dpath
// Datapath: draw registers, bit-serial span/range divider, quotient loop,
// card store with per-entry valid bits, and the result registers.
// ----------------------------------------------------------------------------
module bffy_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  bffy_pkg::dp_cmd_t            cmd,
  output bffy_pkg::dp_status_t         status,
  input  logic                         cfg_write,
  input  logic [bffy_pkg::DECK_W-1:0]  cfg_data,
  input  logic                         random_bit,
  input  logic [bffy_pkg::FIELD_W-1:0] read_position,
  output logic                         result_valid,
  output logic                         kind,
  output logic [bffy_pkg::FIELD_W-1:0] position,
  output logic [bffy_pkg::FIELD_W-1:0] chosen,
  output logic [bffy_pkg::FIELD_W-1:0] card,
  output logic                         shuffle_done
);
  import bffy_pkg::*;

  // architectural state
  logic [DECK_W-1:0]      deck_count;
  logic [FIELD_W-1:0]     pos;
  logic [SPAN_W-1:0]      value;
  logic [SPAN_W-1:0]      span;
  logic [RANGE_W-1:0]     defect;
  logic                   widen;
  logic [STORE_DEPTH-1:0] valid;

  // divider and swap working registers
  logic [RANGE_W-1:0]        div_rem;
  logic [SPAN_W-1:0]         div_sh;
  logic [SPAN_W-1:0]         quo;
  logic [SPAN_W-1:0]         rem_v;
  logic [SPAN_W+FIELD_W-1:0] dsr;
  logic [FIELD_W-1:0]        jq;
  logic [FIELD_W-1:0]        rpos_q;
  logic [FIELD_W-1:0]        tmp_pos;
  logic                      rd_valid_q;
  logic [ADDR_W-1:0]         rd_idx_q;

  // combinational
  logic [DECK_W-1:0]     eff_m1;
  logic [FIELD_W-1:0]    restart_pos;
  logic [RANGE_W-1:0]    range;
  logic [SPAN_W-1:0]     range_s;
  logic [SPAN_W-1:0]     v_or;
  logic [SPAN_W-1:0]     value_next;
  logic [SPAN_W-1:0]     span_next;
  logic [RANGE_W-1:0]    defect_next;
  logic                  widen_next;
  logic                  short_span;
  logic [RANGE_W:0]      def2;
  logic [RANGE_W:0]      div_t;
  logic                  div_ge;
  logic                  j_ge;
  logic [FIELD_W-1:0]    j_final;
  logic [FIELD_W-1:0]    card_eff;
  logic                  pass_end;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [FIELD_W-1:0]    ram_wdata;
  logic [FIELD_W-1:0]    ram_rdata;
  logic                  ram_we;

  always_comb begin
    if (deck_count < DECK_W'(2)) begin
      eff_m1 = DECK_W'(1);
    end else if (deck_count > DECK_W'(STORE_DEPTH)) begin
      eff_m1 = DECK_W'(STORE_DEPTH - 1);
    end else begin
      eff_m1 = deck_count - DECK_W'(1);
    end
  end

  assign restart_pos = eff_m1[FIELD_W-1:0];
  assign range       = {1'b0, pos} + RANGE_W'(1);
  assign range_s     = SPAN_W'(range);
  assign v_or        = random_bit ? (value | span) : value;
  assign def2        = {defect, 1'b0};

  // one random bit: widen, extend into the tail, or slide at the cap
  always_comb begin
    short_span  = 1'b0;
    widen_next  = 1'b0;
    value_next  = v_or;
    span_next   = span;
    defect_next = defect;
    if (widen) begin
      span_next  = span << 1;
      short_span = (span_next < range_s);
      widen_next = short_span;
      if (!short_span) begin
        defect_next = RANGE_W'(span_next - range_s);
      end
    end else if (!span[SPAN_CAP_BITS]) begin
      span_next = span << 1;
      if (def2 >= {1'b0, range}) begin
        defect_next = RANGE_W'(def2 - {1'b0, range});
      end else begin
        defect_next = def2[RANGE_W-1:0];
      end
    end else begin
      value_next = v_or >> 1;
    end
    status.draw_ok = !short_span && (value_next < (span_next - SPAN_W'(defect_next)));
  end

  assign div_t   = {div_rem, div_sh[SPAN_W-1]};
  assign div_ge  = (div_t >= {1'b0, range});
  assign j_ge    = ({{FIELD_W{1'b0}}, rem_v} >= dsr);
  assign j_final = (jq > pos) ? pos : jq;
  assign card_eff = rd_valid_q ? ram_rdata : FIELD_W'(rd_idx_q);
  assign pass_end = (pos <= FIELD_W'(1));

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_POS:  ram_raddr = pos[ADDR_W-1:0];
      ADDR_J:    ram_raddr = j_final[ADDR_W-1:0];
      ADDR_READ: ram_raddr = rpos_q[ADDR_W-1:0];
      default:   ram_raddr = pos[ADDR_W-1:0];
    endcase
  end

  assign ram_we    = cmd.wr_pos | cmd.wr_j;
  assign ram_waddr = cmd.wr_j ? j_final[ADDR_W-1:0] : pos[ADDR_W-1:0];
  assign ram_wdata = cmd.wr_j ? tmp_pos : card_eff;

  bffy_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      deck_count   <= DECK_W'(DECK_SIZE_RESET);
      pos          <= FIELD_W'(DECK_SIZE_RESET - 1);
      value        <= '0;
      span         <= SPAN_W'(1);
      defect       <= '0;
      widen        <= 1'b1;
      valid        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.wr_j | cmd.emit_read;
      if (cfg_write) begin
        deck_count <= cfg_data;
      end
      if (cmd.bit_step) begin
        value  <= value_next;
        span   <= span_next;
        defect <= defect_next;
        widen  <= widen_next;
      end
      if (cmd.init) begin
        valid  <= '0;
        pos    <= restart_pos;
        value  <= '0;
        span   <= SPAN_W'(1);
        defect <= '0;
        widen  <= 1'b1;
      end
      if (cmd.wr_pos) begin
        valid[pos[ADDR_W-1:0]] <= 1'b1;
      end
      if (cmd.wr_j) begin
        valid[j_final[ADDR_W-1:0]] <= 1'b1;
        pos    <= pass_end ? restart_pos : pos - FIELD_W'(1);
        value  <= '0;
        span   <= SPAN_W'(1);
        defect <= '0;
        widen  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_q <= valid[ram_raddr];
    rd_idx_q   <= ram_raddr;
    if (cmd.bit_step) begin
      div_sh  <= span_next;
      div_rem <= '0;
      quo     <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= div_ge ? RANGE_W'(div_t - {1'b0, range}) : div_t[RANGE_W-1:0];
      quo     <= {quo[SPAN_W-2:0], div_ge};
      div_sh  <= div_sh << 1;
    end
    if (cmd.j_load) begin
      dsr   <= {1'b0, quo, {(FIELD_W-1){1'b0}}};
      rem_v <= value;
      jq    <= '0;
    end
    if (cmd.j_step) begin
      if (j_ge) begin
        rem_v <= rem_v - dsr[SPAN_W-1:0];
      end
      jq  <= {jq[FIELD_W-2:0], j_ge};
      dsr <= dsr >> 1;
    end
    if (cmd.read_cap) begin
      rpos_q <= read_position;
    end
    if (cmd.cap_pos) begin
      tmp_pos <= card_eff;
    end
    if (cmd.wr_j) begin
      kind         <= KIND_SWAP;
      position     <= pos;
      chosen       <= j_final;
      card         <= '0;
      shuffle_done <= pass_end;
    end
    if (cmd.emit_read) begin
      kind         <= KIND_READ;
      position     <= rpos_q;
      chosen       <= '0;
      card         <= ({1'b0, rpos_q} < RANGE_W'(STORE_DEPTH)) ? card_eff : '0;
      shuffle_done <= 1'b0;
    end
  end

endmodule

FILE: design/bit_frugal_fisher_yates_shuffler_unit.sv
// ----------------------------------------------------------------------------
// bit_frugal_fisher_yates_shuffler_unit
// Shuffles a card store one random bit at a time.
//
// Commands are taken when start is high and busy is low. Opcode 0 feeds one
// random bit, opcode 1 restores the store to identity and restarts the pass,
// opcode 2 reads one entry. A bit that does not complete a draw and opcode 1
// leave busy low. A bit that completes a draw keeps busy high through the
// bit-serial span/range divider, the load and run of the 6-step partner-index
// loop and the swap through the single read port of the store. The swap
// transaction is on the result ports in the cycle in which busy drops. A read
// also keeps busy high, and its transaction comes in the cycle in which busy
// drops. Each transaction stands on the result ports for one cycle, marked by
// result_valid; the receiver cannot stall. The deck size is written on the
// cfg channel (always ready) while the block is idle; the user must keep to
// this, as the block itself does not enforce it. Reset sets the deck size to
// 52, the store to identity, the position to 51 and clears the draw; no sweep.
// ----------------------------------------------------------------------------
module bit_frugal_fisher_yates_shuffler_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode,
  input  logic                         random_bit,
  input  logic [bffy_pkg::FIELD_W-1:0] read_position,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bffy_pkg::DECK_W-1:0]  cfg_data,
  output logic                         result_valid,
  output logic                         kind,
  output logic [bffy_pkg::FIELD_W-1:0] position,
  output logic [bffy_pkg::FIELD_W-1:0] chosen,
  output logic [bffy_pkg::FIELD_W-1:0] card,
  output logic                         shuffle_done
);
  import bffy_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  bffy_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bffy_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .random_bit    (random_bit),
    .read_position (read_position),
    .result_valid  (result_valid),
    .kind          (kind),
    .position      (position),
    .chosen        (chosen),
    .card          (card),
    .shuffle_done  (shuffle_done)
  );

  a_no_back_to_back_results: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("two result transactions in consecutive cycles");

  a_read_holds_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_READ) |=> busy)
    else $error("read command did not hold busy");

  a_read_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_READ) |-> (chosen == '0 && !shuffle_done))
    else $error("read transaction carries swap fields");

  a_partner_in_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_SWAP) |-> (chosen <= position && card == '0))
    else $error("swap partner beyond position");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the bit-frugal Fisher-Yates shuffler. A class tracks the card
// store, the pass position and the draw in progress, predicts every swap and
// read transaction from the accepted commands, and checks each result strobe
// against the oldest prediction. Stimulus sweeps deck sizes across and beyond
// the legal range, with long runs of equal bits that push the draw into the
// biased tail and up to the span cap, reinitializations, reads, unused
// opcodes and random sender gaps.
// ----------------------------------------------------------------------------
module tb;
  import bffy_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int PHASES = 11;
  localparam int ITEMS_PER_PHASE = 113;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] chosen;
    logic [FIELD_W-1:0] card;
    logic               done;
  } shuffle_event_t;

  class deck_tracker;
    logic [FIELD_W-1:0] cards [STORE_DEPTH];
    logic [FIELD_W-1:0] cur_pos;
    logic [SPAN_W-1:0]  draw_val;
    logic [SPAN_W-1:0]  draw_span;
    logic [RANGE_W-1:0] defect;
    logic               widening;
    logic [DECK_W-1:0]  deck;
    shuffle_event_t     pending[$];
    int unsigned        mismatch_count;

    function new();
      deck = DECK_W'(DECK_SIZE_RESET);
      mismatch_count = 0;
      restart();
    endfunction

    function int unsigned active_size();
      int unsigned n;
      n = deck;
      if (n < 2) n = 2;
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      return n;
    endfunction

    function void clear_draw();
      draw_val = '0;
      draw_span = SPAN_W'(1);
      defect = '0;
      widening = 1'b1;
    endfunction

    function void restart();
      for (int k = 0; k < STORE_DEPTH; k++) cards[k] = FIELD_W'(k);
      cur_pos = FIELD_W'(active_size() - 1);
      clear_draw();
    endfunction

    function void set_deck(logic [DECK_W-1:0] v);
      deck = v;
    endfunction

    function void take_command(logic [1:0] op, logic rbit, logic [FIELD_W-1:0] rpos);
      int unsigned choices, val, span, j;
      logic [FIELD_W-1:0] tmp;
      shuffle_event_t ev;
      ev = '0;
      case (op)
        OP_INIT: begin
          restart();
        end
        OP_READ: begin
          ev.kind = KIND_READ;
          ev.position = rpos;
          ev.card = (rpos < STORE_DEPTH) ? cards[rpos] : '0;
          pending.push_back(ev);
        end
        OP_BIT: begin
          choices = cur_pos + 1;
          val = draw_val;
          span = draw_span;
          if (widening) begin
            if (rbit) val |= span;
            span = span << 1;
            draw_val = SPAN_W'(val);
            draw_span = SPAN_W'(span);
            if (span < choices) return;
            defect = RANGE_W'(span % choices);
            widening = 1'b0;
          end else begin
            if (rbit) val |= span;
            if (span < (32'd1 << SPAN_CAP_BITS)) begin
              span = span << 1;
              defect = RANGE_W'(span % choices);
            end else begin
              val = val >> 1;
            end
            draw_val = SPAN_W'(val);
            draw_span = SPAN_W'(span);
          end
          if (val >= span - defect) return;
          j = val / (span / choices);
          if (j > cur_pos) j = cur_pos;
          tmp = cards[cur_pos];
          cards[cur_pos] = cards[j];
          cards[j] = tmp;
          ev.kind = KIND_SWAP;
          ev.position = cur_pos;
          ev.chosen = FIELD_W'(j);
          ev.done = (cur_pos <= 1);
          pending.push_back(ev);
          if (ev.done) cur_pos = FIELD_W'(active_size() - 1);
          else cur_pos = cur_pos - 1'b1;
          clear_draw();
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, actual %0d", name, exp, act);
        mismatch_count++;
      end
    endfunction

    function void match_result(logic k, logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] c,
                               logic [FIELD_W-1:0] cd, logic d);
      shuffle_event_t ev;
      if (pending.size() == 0) begin
        $error("unexpected transaction: kind %0d position %0d chosen %0d card %0d",
               k, p, c, cd);
        mismatch_count++;
        return;
      end
      ev = pending.pop_front();
      compare_field("kind", ev.kind, k);
      compare_field("position", ev.position, p);
      compare_field("chosen", ev.chosen, c);
      compare_field("card", ev.card, cd);
      compare_field("shuffle_done", ev.done, d);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode = OP_BIT;
  logic               random_bit = 1'b0;
  logic [FIELD_W-1:0] read_position = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [DECK_W-1:0]  cfg_data = '0;
  logic               result_valid;
  logic               kind;
  logic [FIELD_W-1:0] position;
  logic [FIELD_W-1:0] chosen;
  logic [FIELD_W-1:0] card;
  logic               shuffle_done;

  deck_tracker book;
  int unsigned cycle_count = 0;

  bit_frugal_fisher_yates_shuffler_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .random_bit(random_bit),
    .read_position(read_position),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .kind(kind),
    .position(position),
    .chosen(chosen),
    .card(card),
    .shuffle_done(shuffle_done)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && book != null) begin
      if (result_valid) book.match_result(kind, position, chosen, card, shuffle_done);
      if (start && !busy) book.take_command(opcode, random_bit, read_position);
      if (cfg_valid && cfg_ready) book.set_deck(cfg_data);
    end
  end

  task automatic issue(logic [1:0] op, logic b, logic [FIELD_W-1:0] rp);
    start <= 1'b1;
    opcode <= op;
    random_bit <= b;
    read_position <= rp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_sender();
    int unsigned gap;
    if ($urandom_range(0, 99) < 28) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 45) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (book.pending.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_deck(logic [DECK_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned deck_plan [PHASES];
    bit reinit_plan [PHASES];
    int unsigned sel, run_len;
    logic [DECK_W-1:0] deck_v;
    logic b;
    bit steady;
    deck_plan = '{52, 2, 0, 64, 1, 127, 3, 65, 17, 0, 0};
    reinit_plan = '{1, 1, 1, 1, 0, 1, 0, 1, 1, 0, 0};
    book = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    issue(OP_READ, 1'b0, '0);
    issue(OP_READ, 1'b1, '1);
    issue(OP_UNUSED, 1'b1, '1);
    issue(OP_BIT, 1'b1, '0);
    issue(OP_BIT, 1'b0, '0);
    issue(OP_BIT, 1'b1, '0);
    issue(OP_BIT, 1'b0, '0);
    issue(OP_BIT, 1'b0, '0);
    issue(OP_BIT, 1'b0, '0);
    repeat (6) issue(OP_BIT, 1'b1, '1);
    issue(OP_BIT, 1'b0, '1);
    issue(OP_READ, 1'b0, FIELD_W'(51));
    issue(OP_READ, 1'b0, FIELD_W'(5));
    issue(OP_INIT, 1'b1, '1);
    issue(OP_READ, 1'b0, FIELD_W'(51));
    issue(OP_READ, 1'b1, FIELD_W'(31));

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p >= 9) deck_v = DECK_W'($urandom_range(0, 127));
      else deck_v = DECK_W'(deck_plan[p]);
      write_deck(deck_v);
      if (reinit_plan[p] || (p >= 9 && $urandom_range(0, 1) == 1))
        issue(OP_INIT, 1'($urandom_range(0, 1)), FIELD_W'($urandom_range(0, 63)));
      steady = (p == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 2) begin
          run_len = $urandom_range(20, 34);
          b = 1'($urandom_range(0, 1));
          repeat (run_len) issue(OP_BIT, b, FIELD_W'($urandom_range(0, 63)));
        end else if (sel < 80) begin
          issue(OP_BIT, 1'($urandom_range(0, 1)), FIELD_W'($urandom_range(0, 63)));
        end else if (sel < 94) begin
          issue(OP_READ, 1'($urandom_range(0, 1)), FIELD_W'($urandom_range(0, 63)));
        end else if (sel < 95) begin
          issue(OP_INIT, 1'($urandom_range(0, 1)), FIELD_W'($urandom_range(0, 63)));
        end else begin
          issue(OP_UNUSED, 1'($urandom_range(0, 1)), FIELD_W'($urandom_range(0, 63)));
        end
        if ($urandom_range(0, 99) == 0) drain();
        else if (!steady) idle_sender();
      end
    end

    settle();
    if (book.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
